### hw/rtl/tdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared widths, microcode encoding and control ROM for the prime tester.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int NUM_WIDTH = 32;                      // candidate width as tested
    localparam int IN_WIDTH  = 32;                      // candidate port width
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH);       // divider bit counter
    localparam int PC_WIDTH  = 3;

    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;
    typedef logic [PC_WIDTH-1:0]  pc_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ACCEPT = 3'd1,   // load candidate, divisor = 2
        OP_INIT   = 3'd2,   // start first division, clear flag
        OP_DIV    = 3'd3,   // one restoring division bit
        OP_SET    = 3'd4,   // flag = prime
        OP_CLR    = 3'd5,   // flag = not prime
        OP_NEXT   = 3'd6,   // divisor + 1, restart division
        OP_REPORT = 3'd7    // move flag to output register if free
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        JC_NEVER    = 3'd0,
        JC_ALWAYS   = 3'd1,
        JC_NO_INPUT = 3'd2,
        JC_SMALL    = 3'd3,
        JC_DIV_BUSY = 3'd4,
        JC_D_GT_Q   = 3'd5,
        JC_REM_ZERO = 3'd6,
        JC_OUT_BUSY = 3'd7
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic init;
        logic step;
    } div_ctrl_t;

    localparam pc_t STEP_WAIT   = 3'd0;
    localparam pc_t STEP_INIT   = 3'd1;
    localparam pc_t STEP_DIV    = 3'd2;
    localparam pc_t STEP_TEST   = 3'd3;
    localparam pc_t STEP_ZERO   = 3'd4;
    localparam pc_t STEP_NEXT   = 3'd5;
    localparam pc_t STEP_REPORT = 3'd6;

    // control store: a taken jump goes to target, otherwise the next step (report falls back to wait)
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        begin
            case (pc)
                STEP_WAIT:   w = '{OP_ACCEPT, JC_NO_INPUT, STEP_WAIT};
                STEP_INIT:   w = '{OP_INIT,   JC_SMALL,    STEP_REPORT};
                STEP_DIV:    w = '{OP_DIV,    JC_DIV_BUSY, STEP_DIV};
                STEP_TEST:   w = '{OP_SET,    JC_D_GT_Q,   STEP_REPORT};
                STEP_ZERO:   w = '{OP_CLR,    JC_REM_ZERO, STEP_REPORT};
                STEP_NEXT:   w = '{OP_NEXT,   JC_ALWAYS,   STEP_DIV};
                STEP_REPORT: w = '{OP_REPORT, JC_OUT_BUSY, STEP_REPORT};
                default:     w = '{OP_NONE,   JC_ALWAYS,   STEP_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/tdp_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_divider
// Restoring shift-subtract divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module tdp_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tdp_pkg::div_ctrl_t ctrl,
    input  wire tdp_pkg::num_t      dividend,
    input  wire tdp_pkg::num_t      divisor,
    output tdp_pkg::num_t           quotient,
    output tdp_pkg::num_t           remainder,
    output logic                    last
);
    import tdp_pkg::*;

    num_t rem_reg, rem_next;
    num_t qs_reg,  qs_next;     // dividend bits out at the top, quotient bits in
    cnt_t cnt_reg, cnt_next;

    logic [NUM_WIDTH:0] trial;
    logic [NUM_WIDTH:0] diff;

    always_comb
    begin
        trial    = {rem_reg, qs_reg[NUM_WIDTH-1]};
        diff     = trial - {1'b0, divisor};
        rem_next = rem_reg;
        qs_next  = qs_reg;
        cnt_next = cnt_reg;
        if (ctrl.init)
        begin
            rem_next = '0;
            qs_next  = dividend;
            cnt_next = '0;
        end
        else if (ctrl.step)
        begin
            if (!diff[NUM_WIDTH])
            begin
                rem_next = diff[NUM_WIDTH-1:0];
                qs_next  = {qs_reg[NUM_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[NUM_WIDTH-1:0];
                qs_next  = {qs_reg[NUM_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qs_reg  <= qs_next;
    end

    assign quotient  = qs_reg;
    assign remainder = rem_reg;
    assign last      = (cnt_reg == cnt_t'(NUM_WIDTH - 1));

endmodule
`default_nettype wire

### hw/rtl/trial_division_prime_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Input channel: candidate with in_valid / in_stall. in_stall is low only while
// the sequencer waits for work, so one candidate is in flight at a time.
// Output channel: is_prime with out_valid / out_stall, held in an output
// register; the next candidate is taken while a result still waits there.
// Divisors d = 2, 3, ... are tried; each trial is one NUM_WIDTH-step restoring
// division giving n / d and n % d. The test ends as prime once d > n / d and as
// composite on a zero remainder. Values below 2 are reported not prime.
// Run time grows with the number k of divisions tried; values below 2 skip the
// divider, and a composite also passes the zero step after its last division;
// with NUM_WIDTH = 32 the worst case (k near 65536) is set by the bit-serial
// divider.
// A result waits at the report step while the output register is full and
// stalled. Reset returns the sequencer to its wait step, empties the output
// register and clears the divider bit counter; other registers are not reset.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [tdp_pkg::IN_WIDTH-1:0] candidate,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             is_prime
);
    import tdp_pkg::*;

    pc_t    pc_reg, pc_next;
    ucode_t uw;
    logic   jump;

    num_t n_reg, n_next;
    num_t d_reg, d_next;
    logic flag_reg, flag_next;
    logic out_valid_reg, out_valid_next;
    logic is_prime_reg, is_prime_next;

    div_ctrl_t div_ctrl;
    num_t      quotient;
    num_t      remainder;
    logic      div_last;
    logic      out_busy;

    tdp_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .last      (div_last)
    );

    assign uw       = ucode_rom(pc_reg);
    assign out_busy = out_valid_reg & out_stall;
    assign in_stall = (pc_reg != STEP_WAIT);

    always_comb
    begin
        case (uw.cond)
            JC_NEVER:    jump = 1'b0;
            JC_ALWAYS:   jump = 1'b1;
            JC_NO_INPUT: jump = !in_valid;
            JC_SMALL:    jump = (n_reg < num_t'(2));
            JC_DIV_BUSY: jump = !div_last;
            JC_D_GT_Q:   jump = (d_reg > quotient);
            JC_REM_ZERO: jump = (remainder == '0);
            JC_OUT_BUSY: jump = out_busy;
            default:     jump = 1'b0;
        endcase
        if (jump)
            pc_next = uw.target;
        else if (pc_reg == STEP_REPORT)
            pc_next = STEP_WAIT;
        else
            pc_next = pc_reg + pc_t'(1);
    end

    always_comb
    begin
        n_next         = n_reg;
        d_next         = d_reg;
        flag_next      = flag_reg;
        is_prime_next  = is_prime_reg;
        out_valid_next = out_valid_reg & out_stall;
        div_ctrl       = '{init: 1'b0, step: 1'b0};
        case (uw.op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    n_next = num_t'(candidate);
                    d_next = num_t'(2);
                end
            end
            OP_INIT:
            begin
                div_ctrl.init = 1'b1;
                flag_next     = 1'b0;
            end
            OP_DIV:    div_ctrl.step = 1'b1;
            OP_SET:    flag_next = 1'b1;
            OP_CLR:    flag_next = 1'b0;
            OP_NEXT:
            begin
                d_next        = d_reg + num_t'(1);
                div_ctrl.init = 1'b1;
            end
            OP_REPORT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = flag_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        flag_reg     <= flag_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    // an accepted transaction always starts the program at its init step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (pc_reg == STEP_INIT))
        else $error("accepted transaction did not reach init step");

    // results are only produced from the report step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) == STEP_REPORT))
        else $error("output loaded outside report step");

    // divisor is never below two while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_DIV) |-> (d_reg >= num_t'(2)))
        else $error("trial divisor below two");

    // a prime verdict is never given for a value below two
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && is_prime_reg) |-> (n_reg >= num_t'(2)))
        else $error("value below two reported prime");

endmodule
`default_nettype wire

### verif/trial_division_prime_test_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_test
// Self-checking bench for the trial-division prime tester. Candidates are
// pushed through the valid/stall input channel. Each accepted candidate gets
// a predicted flag from a trial-division predictor kept in the bench. Flags
// that come back are checked in order against those predictions. Random
// gaps are applied on the input channel and hold-offs on the output channel.
// ----------------------------------------------------------------------------
module trial_division_prime_test_test;
    import tdp_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TRIAL_BUDGET   = 600;     // keeps random candidates cheap to test
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 75;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct {
        logic [IN_WIDTH-1:0] candidate;
        logic                flag;
    } verdict_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [IN_WIDTH-1:0] candidate;
    logic                out_valid;
    logic                out_stall;
    logic                is_prime;

    verdict_t pending_verdicts[$];
    int       failures        = 0;
    int       items_sent      = 0;
    int       results_checked = 0;
    int       primes_seen     = 0;
    int       quiet_cycles    = 0;
    bit       sender_steady   = 1'b0;
    bit       receiver_steady = 1'b0;
    bit       hold_request    = 1'b0;

    trial_division_prime_test DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    always #HALF_PERIOD clk = ~clk;

    // trial division on the low NUM_WIDTH bits; trials tells how costly it was
    function automatic logic primality(input logic [IN_WIDTH-1:0] value, output int trials);
        logic [63:0] n;
        logic [63:0] d;
        logic        flag;
        n      = 64'(value) & ((~64'd0) >> (64 - NUM_WIDTH));
        trials = 0;
        flag   = (n >= 64'd2);
        d      = 64'd2;
        while (flag && d <= n / d)
        begin
            trials++;
            if (n % d == 64'd0)
                flag = 1'b0;
            d++;
        end
        return flag;
    endfunction

    // mix of small, mid and full-range values; slow-to-decide ones are redrawn
    function automatic logic [IN_WIDTH-1:0] draw_candidate();
        logic [IN_WIDTH-1:0] value;
        int                  trials;
        int                  pick;
        do
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                value = $urandom_range(0, 200);
            else if (pick < 55)
                value = $urandom_range(0, 65535);
            else if (pick < 70)
                value = $urandom_range(65536, 1 << 20);
            else
                value = $urandom;
            void'(primality(value, trials));
        end
        while (trials > TRIAL_BUDGET);
        return value;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // valid stays high into the next call when no gap is drawn
    task automatic send_candidate(input logic [IN_WIDTH-1:0] value);
        int       gap;
        int       trials;
        verdict_t v;
        @(negedge clk);
        in_valid  = 1'b1;
        candidate = value;
        do
            @(posedge clk);
        while (in_stall);
        v.candidate = value;
        v.flag      = primality(value, trials);
        pending_verdicts.push_back(v);
        items_sent++;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_special_cases();
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        // zero to three, squares where d*d == n ends the search, primes 5 and 97
        send_candidate(32'd0);
        send_candidate(32'd1);
        send_candidate(32'd2);
        send_candidate(32'd3);
        send_candidate(32'd4);
        send_candidate(32'd5);
        send_candidate(32'd9);
        send_candidate(32'd25);
        send_candidate(32'd49);
        send_candidate(32'd121);
        send_candidate(32'd97);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        send_candidate(32'hFFFF_FFFF);
        send_candidate(32'hFFFF_FFFE);
        send_candidate(32'h8000_0000);
        send_candidate(32'h8000_0001);
        send_candidate(32'hAAAA_AAAA);
        send_candidate(32'h5555_5555);
        send_candidate(32'd65521);
        send_candidate(32'd1042441);
        send_candidate(32'd1048573);
        wait_drained();
    endtask

    // receiver holds off while candidates keep coming, so the input backs up
    task automatic test_output_backpressure();
        sender_steady = 1'b1;
        hold_request  = 1'b1;
        for (int i = 0; i < 6; i++)
            send_candidate($urandom_range(0, 300));
        wait_drained();
        while (hold_request)
            @(posedge clk);
        sender_steady = 1'b0;
    endtask

    task automatic test_random_candidates();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
            begin
                // full pause until every flag is back, then change the idling mix
                wait_drained();
                sender_steady   = (i == 0);
                receiver_steady = (i == 0) || (i == 50);
            end
            send_candidate(draw_candidate());
        end
        wait_drained();
    endtask

    // receiver side
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (receiver_steady)
                out_stall = 1'b0;
            else if ($urandom_range(0, 99) < 3)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(10, 40) - 1) @(negedge clk);
            end
            else
                out_stall = ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual is_prime=%0b",
                         $time, is_prime);
                failures++;
            end
            else
            begin
                v = pending_verdicts.pop_front();
                results_checked++;
                if (v.flag)
                    primes_seen++;
                if (is_prime !== v.flag)
                begin
                    $display("%0t: candidate %0d: expected is_prime=%0b, actual %0b",
                             $time, v.candidate, v.flag, is_prime);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d flags outstanding",
                         $time, quiet_cycles, pending_verdicts.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        candidate = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_field_extremes();
        test_output_backpressure();
        test_random_candidates();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Tested %0d candidates, %0d flags checked (%0d prime)",
                 items_sent, results_checked, primes_seen);
        $display("Covered small cases, 32-bit extremes, output hold-off and random idling");
        if (failures == 0 && pending_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
